[sv/aes_pkg.sv]
// Shared types, constants and byte functions for the AES-128 block.
package aes_pkg;

    localparam int unsigned NR = 10;

    typedef enum logic [0:0] {
        ACT_ENC = 1'b0,
        ACT_DEC = 1'b1
    } action_t;

    localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [0:0] CFG_KEY_LOW  = 1'b1;

    // Controller commands to the datapath.
    typedef struct packed {
        logic       load;       // capture input word and apply first key
        logic       round;      // run one round
        logic       last;       // final round: no column mix
        logic       key_start;  // load the cipher key into the schedule
        logic       key_step;   // advance the schedule by one round key
        logic [3:0] rk_idx;     // round key index for this cycle
    } aes_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a 128-bit word sits in bits 127-8i downto 120-8i.
    function automatic logic [7:0] byte_at(input logic [127:0] w, input int i);
        byte_at = w[127 - 8 * i -: 8];
    endfunction

endpackage

[sv/aes_ctrl.sv]
// Round sequencer and key-schedule sequencer for the AES-128 block.
module aes_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                in_action,
    input  logic                key_write,
    input  logic                out_fire,
    output logic                in_ready,
    output logic                out_valid,
    output aes_pkg::aes_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] round_reg, round_next;
    logic       dec_reg, dec_next;
    logic       key_busy_reg, key_busy_next;
    logic       key_pend_reg, key_pend_next;
    logic [3:0] key_cnt_reg, key_cnt_next;

    assign in_ready  = (state_reg == ST_IDLE) && !key_busy_reg && !key_pend_reg;
    assign out_valid = (state_reg == ST_DONE);

    always_comb
    begin
        state_next    = state_reg;
        round_next    = round_reg;
        dec_next      = dec_reg;
        key_busy_next = key_busy_reg;
        key_pend_next = key_pend_reg;
        key_cnt_next  = key_cnt_reg;
        cmd           = '0;
        // key schedule: start the cycle after a write, then ten steps
        if (key_write)
        begin
            key_pend_next = 1'b1;
            key_busy_next = 1'b0;
        end
        else if (key_pend_reg)
        begin
            cmd.key_start = 1'b1;
            key_pend_next = 1'b0;
            key_busy_next = 1'b1;
            key_cnt_next  = 4'd1;
        end
        else if (key_busy_reg)
        begin
            cmd.key_step = 1'b1;
            key_cnt_next = key_cnt_reg + 4'd1;
            if (key_cnt_reg == 4'(aes_pkg::NR))
            begin
                key_busy_next = 1'b0;
            end
        end
        cmd.rk_idx = key_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    cmd.rk_idx = in_action ? 4'(aes_pkg::NR) : 4'd0;
                    dec_next   = in_action;
                    round_next = 4'd1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.round  = 1'b1;
                cmd.last   = (round_reg == 4'(aes_pkg::NR));
                cmd.rk_idx = dec_reg ? 4'(aes_pkg::NR) - round_reg : round_reg;
                round_next = round_reg + 4'd1;
                if (round_reg == 4'(aes_pkg::NR))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            round_reg    <= '0;
            dec_reg      <= 1'b0;
            key_busy_reg <= 1'b0;
            key_pend_reg <= 1'b0;
            key_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            dec_reg      <= dec_next;
            key_busy_reg <= key_busy_next;
            key_pend_reg <= key_pend_next;
            key_cnt_reg  <= key_cnt_next;
        end
    end

endmodule

[sv/aes_dpath.sv]
// Round datapath, key schedule and round key store for the AES-128 block.
module aes_dpath
(
    input  logic                clk,
    input  aes_pkg::aes_cmd_t   cmd,
    input  logic                in_dec,
    input  logic [127:0]        in_block,
    input  logic [127:0]        key,
    output logic [127:0]        result
);

    logic [127:0] state_reg;
    logic         dec_reg;
    logic [127:0] sched_reg;
    logic [7:0]   rcon_reg;
    logic [127:0] rk_mem [2 * (aes_pkg::NR + 1) / 2];
    logic [127:0] rk;
    logic [127:0] sched_next;
    logic [127:0] fwd_out;
    logic [127:0] inv_out;

    // Round key store; the schedule word written at cmd.rk_idx.
    assign rk = rk_mem[cmd.rk_idx];

    always_comb
    begin
        logic [31:0] t;
        logic [31:0] w;
        t = {aes_pkg::SBOX[sched_reg[23:16]] ^ rcon_reg, aes_pkg::SBOX[sched_reg[15:8]],
             aes_pkg::SBOX[sched_reg[7:0]], aes_pkg::SBOX[sched_reg[31:24]]};
        w = sched_reg[127:96] ^ t;
        sched_next[127:96] = w;
        w = sched_reg[95:64] ^ w;
        sched_next[95:64] = w;
        w = sched_reg[63:32] ^ w;
        sched_next[63:32] = w;
        sched_next[31:0] = sched_reg[31:0] ^ w;
    end

    // Forward round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
    always_comb
    begin
        logic [7:0] s [16];
        logic [7:0] a0, a1, a2, a3;
        for (int i = 0; i < 16; i++)
        begin
            s[i] = aes_pkg::SBOX[aes_pkg::byte_at(state_reg, ((i & 3) + 4 * (((i >> 2) + (i & 3)) & 3)))];
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
            if (!cmd.last)
            begin
                s[4 * c]     = aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
                s[4 * c + 1] = a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3;
                s[4 * c + 2] = a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3;
                s[4 * c + 3] = aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            fwd_out[127 - 8 * i -: 8] = s[i] ^ aes_pkg::byte_at(rk, i);
        end
    end

    // Inverse round: InvShiftRows, InvSubBytes, AddRoundKey, optional InvMixColumns.
    always_comb
    begin
        logic [7:0] s [16];
        logic [7:0] a0, a1, a2, a3, u, v;
        for (int i = 0; i < 16; i++)
        begin
            s[i] = aes_pkg::INV_SBOX[aes_pkg::byte_at(state_reg,
                   ((i & 3) + 4 * (((i >> 2) - (i & 3)) & 3)))] ^ aes_pkg::byte_at(rk, i);
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
            // factor 0e/0b/0d/09 as (02 03 01 01) after a pre-step
            u = aes_pkg::xtime(aes_pkg::xtime(a0 ^ a2));
            v = aes_pkg::xtime(aes_pkg::xtime(a1 ^ a3));
            a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
            if (!cmd.last)
            begin
                s[4 * c]     = aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
                s[4 * c + 1] = a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3;
                s[4 * c + 2] = a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3;
                s[4 * c + 3] = aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            inv_out[127 - 8 * i -: 8] = s[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.key_start)
        begin
            sched_reg <= key;
            rcon_reg  <= 8'h01;
            rk_mem[0] <= key;
        end
        else if (cmd.key_step)
        begin
            sched_reg         <= sched_next;
            rcon_reg          <= aes_pkg::xtime(rcon_reg);
            rk_mem[cmd.rk_idx] <= sched_next;
        end
        if (cmd.load)
        begin
            state_reg <= in_block ^ rk;
            dec_reg   <= in_dec;
        end
        else if (cmd.round)
        begin
            state_reg <= dec_reg ? inv_out : fwd_out;
        end
    end

    assign result = state_reg;

endmodule

[sv/aes128_block_cipher_top.sv]
// AES-128 encrypt/decrypt block: round sequencer plus single round datapath.
// The result word is valid once the first key addition, on the accepting edge, and ten rounds
// at one per cycle on the shared round unit have run. The next input word is taken only after
// the result has been taken, when the sequencer has gone from done back to idle. No word is
// taken while the schedule runs after a key write: one key load, then ten round keys at one
// per cycle.
// Reset (rst_n, asynchronous) clears control and both key registers to zero.
module aes128_block_cipher_top
(
    input  logic          clk,
    input  logic          rst_n,
    // s_tdata: [63:0] block_high, [127:64] block_low; s_tuser: [0] action
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,
    input  logic [0:0]    s_tuser,
    // m_tdata: [63:0] result_high, [127:64] result_low
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,
    input  logic          cfg_we,
    input  logic [0:0]    cfg_index,
    input  logic [63:0]   cfg_data
);

    logic              key_write;
    logic [63:0]       key_high_reg;
    logic [63:0]       key_low_reg;
    aes_pkg::aes_cmd_t cmd;
    logic              in_fire;
    logic              out_fire;
    logic [127:0]      result_word;

    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;
    assign key_write = cfg_we;

    // Present the high half in the low tdata bits.
    assign m_tdata   = {result_word[63:0], result_word[127:64]};

    // Hold the key registers; any write restarts the schedule.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aes_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data;
                aes_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    aes_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_action (s_tuser[0]),
        .key_write (key_write),
        .out_fire  (out_fire),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .cmd       (cmd)
    );

    // Datapath works on the block with byte 0 in the top bits.
    aes_dpath u_dpath
    (
        .clk      (clk),
        .cmd      (cmd),
        .in_dec   (s_tuser[0]),
        .in_block ({s_tdata[63:0], s_tdata[127:64]}),
        .key      ({key_high_reg, key_low_reg}),
        .result   (result_word)
    );

endmodule

[bench/aes128_block_cipher_checker.sv]
`timescale 1ns / 1ps
// Checker for the AES-128 block: watches both streams, predicts each result word and compares.
module aes128_block_cipher_checker
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [127:0]  s_tdata,
    input  logic [0:0]    s_tuser,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [127:0]  m_tdata,
    input  logic          cfg_we,
    input  logic [0:0]    cfg_index,
    input  logic [63:0]   cfg_data,
    output int            fail_count,
    output int            pending
);

    typedef logic [7:0] blk_t [16];

    logic [7:0]   sub_lut [256];
    logic [7:0]   inv_lut [256];
    logic [63:0]  key_hi, key_lo;
    logic [127:0] sched [11];
    logic [127:0] result_q [$];

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    // Build the substitution tables from the field inverse and affine map.
    function automatic void build_luts();
        logic [7:0] inv, s;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h01;
            for (int i = 0; i < 254; i++)
                inv = gmul(inv, x[7:0]);
            if (x == 0)
                inv = 8'h00;
            s = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
            sub_lut[x] = s;
            inv_lut[s] = x[7:0];
        end
    endfunction

    function automatic blk_t split(input logic [127:0] w);
        blk_t b;
        for (int i = 0; i < 16; i++)
            b[i] = w[127 - 8 * i -: 8];
        return b;
    endfunction

    function automatic logic [127:0] join_bytes(input blk_t b);
        logic [127:0] w;
        for (int i = 0; i < 16; i++)
            w[127 - 8 * i -: 8] = b[i];
        return w;
    endfunction

    function automatic void expand_schedule();
        blk_t rk, prev;
        logic [7:0] t [4];
        logic [7:0] rc;
        rc = 8'h01;
        rk = split({key_hi, key_lo});
        sched[0] = {key_hi, key_lo};
        for (int r = 1; r <= 10; r++)
        begin
            prev = rk;
            t[0] = sub_lut[prev[13]] ^ rc;
            t[1] = sub_lut[prev[14]];
            t[2] = sub_lut[prev[15]];
            t[3] = sub_lut[prev[12]];
            rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            for (int j = 0; j < 4; j++)
                for (int i = 0; i < 4; i++)
                begin
                    rk[4 * j + i] = prev[4 * j + i] ^ t[i];
                    t[i] = rk[4 * j + i];
                end
            sched[r] = join_bytes(rk);
        end
    endfunction

    function automatic blk_t shift(input blk_t s, input bit inverse);
        blk_t o;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (inverse)
                    o[r + 4 * ((c + r) & 3)] = s[r + 4 * c];
                else
                    o[r + 4 * c] = s[r + 4 * ((c + r) & 3)];
        return o;
    endfunction

    function automatic blk_t mix(input blk_t s, input bit inverse);
        logic [7:0] m [4];
        blk_t o;
        logic [7:0] v;
        if (inverse)
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                v = 8'h00;
                for (int k = 0; k < 4; k++)
                    v ^= gmul(s[4 * c + k], m[(k - r) & 3]);
                o[4 * c + r] = v;
            end
        return o;
    endfunction

    function automatic logic [127:0] cipher_block(input aes_pkg::action_t act,
                                                  input logic [127:0] blk);
        logic [127:0] w;
        blk_t s;
        if (act == aes_pkg::ACT_ENC)
        begin
            w = blk ^ sched[0];
            for (int r = 1; r <= 10; r++)
            begin
                s = split(w);
                for (int i = 0; i < 16; i++)
                    s[i] = sub_lut[s[i]];
                s = shift(s, 1'b0);
                if (r < 10)
                    s = mix(s, 1'b0);
                w = join_bytes(s) ^ sched[r];
            end
        end
        else
        begin
            w = blk ^ sched[10];
            for (int r = 9; r >= 0; r--)
            begin
                s = shift(split(w), 1'b1);
                for (int i = 0; i < 16; i++)
                    s[i] = inv_lut[s[i]];
                w = join_bytes(s) ^ sched[r];
                if (r > 0)
                    w = join_bytes(mix(split(w), 1'b1));
            end
        end
        return w;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        build_luts();
    end

    // tdata carries the high half in its low bits.
    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] want;
        logic [127:0] blk;
        if (!rst_n)
        begin
            fail_count = 0;
            pending    = 0;
            key_hi     = '0;
            key_lo     = '0;
            result_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    report("unexpected word, result_high", m_tdata[63:0], 64'h0);
                end
                else
                begin
                    want = result_q[0];
                    result_q.delete(0);
                    if (m_tdata[63:0] !== want[127:64])
                        report("result_high", m_tdata[63:0], want[127:64]);
                    if (m_tdata[127:64] !== want[63:0])
                        report("result_low", m_tdata[127:64], want[63:0]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                blk = {s_tdata[63:0], s_tdata[127:64]};
                result_q.insert(result_q.size(),
                                cipher_block(aes_pkg::action_t'(s_tuser), blk));
            end
            if (cfg_we)
            begin
                if (cfg_index == aes_pkg::CFG_KEY_HIGH)
                    key_hi = cfg_data;
                else
                    key_lo = cfg_data;
                expand_schedule();
            end
            pending = result_q.size();
        end
    end

endmodule

[bench/tb_aes128_block_cipher_top.sv]
`timescale 1ns / 1ps
// Testbench top for the AES-128 block: drives key writes and block words, gives the verdict.
module tb_aes128_block_cipher_top;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [127:0]  s_tdata;    // [63:0] block_high, [127:64] block_low
    logic [0:0]    s_tuser;    // [0] action
    logic          m_tvalid;
    logic          m_tready = 1'b1;
    logic [127:0]  m_tdata;    // [63:0] result_high, [127:64] result_low
    logic          cfg_we;
    logic [0:0]    cfg_index;
    logic [63:0]   cfg_data;
    int            fail_count;
    int            pending;
    bit            stall_on = 1'b0;

    aes128_block_cipher_top i_dut (.*);

    aes128_block_cipher_checker i_chk (.*);

    always #6 clk = ~clk;

    // Receiver stall pattern: long quiet stretches, then phases of heavy random back-pressure.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_on <= ~stall_on;
        m_tready <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
    end

    // Write one key register; only called with the block idle.
    task automatic write_key(input logic [0:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        // hold off while the schedule expands
        repeat (20) @(negedge clk);
    endtask

    // Present one word and hold it until the block takes it; high half in the low bits.
    task automatic send_word(input aes_pkg::action_t act, input logic [127:0] blk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {blk[63:0], blk[127:64]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid for a random gap, sometimes none so bursts run back to back.
    task automatic gap();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : 0;
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (15) @(negedge clk);
    endtask

    function automatic logic [127:0] rand_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    initial
    begin
        logic [127:0] pt;
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = aes_pkg::ACT_ENC;
        cfg_we    = 1'b0;
        cfg_index = aes_pkg::CFG_KEY_HIGH;
        cfg_data  = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: standard test key, with the key registers written one at a time.
        write_key(aes_pkg::CFG_KEY_HIGH, 64'h2b7e151628aed2a6);
        send_word(aes_pkg::ACT_ENC, 128'h3243f6a8885a308d313198a2e0370734);
        drain();
        write_key(aes_pkg::CFG_KEY_LOW, 64'habf7158809cf4f3c);
        send_word(aes_pkg::ACT_ENC, 128'h3243f6a8885a308d313198a2e0370734);
        send_word(aes_pkg::ACT_DEC, 128'h3925841d02dc09fbdc118597196a0b32);
        send_word(aes_pkg::ACT_ENC, '0);
        send_word(aes_pkg::ACT_ENC, '1);
        send_word(aes_pkg::ACT_DEC, '0);
        send_word(aes_pkg::ACT_DEC, '1);
        send_word(aes_pkg::ACT_ENC, 128'h80000000000000000000000000000001);
        drain();

        // Extreme keys: all zeros and all ones.
        write_key(aes_pkg::CFG_KEY_HIGH, '0);
        write_key(aes_pkg::CFG_KEY_LOW, '0);
        send_word(aes_pkg::ACT_ENC, '0);
        send_word(aes_pkg::ACT_DEC, '1);
        drain();
        write_key(aes_pkg::CFG_KEY_HIGH, '1);
        write_key(aes_pkg::CFG_KEY_LOW, '1);
        send_word(aes_pkg::ACT_ENC, '1);
        send_word(aes_pkg::ACT_DEC, '0);
        drain();

        // Random phases with fresh keys; encrypt and decrypt words mixed at random.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_key(aes_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
            write_key(aes_pkg::CFG_KEY_LOW, {$urandom, $urandom});
            for (int k = 0; k < 50; k++)
            begin
                pt = rand_block();
                send_word(aes_pkg::action_t'($urandom_range(0, 1)), pt);
                gap();
            end
            drain();
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
